// File: rtl/psbc_pkg.sv
`default_nettype none

package psbc_pkg;

  // Portal geometry and fixed-point formats
  localparam int CORNERS   = 8;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 5;
  localparam int CLIP_W    = 32;
  localparam int SCR_W     = 24;
  localparam int DIV_STEPS = SCR_W;
  localparam int STEP_W    = 5;

  localparam logic signed [SCR_W-1:0] Q_ONE     = 24'sh010000;
  localparam logic signed [SCR_W-1:0] Q_NEG_ONE = 24'shFF0000;
  localparam logic signed [SCR_W-1:0] SCR_MAX   = 24'sh7FFFFF;
  localparam logic signed [SCR_W-1:0] SCR_MIN   = 24'sh800000;

  // Count values that mean every corner lies past one side
  localparam logic [CNT_W-1:0] CNT_ALL_POS = CNT_W'(CORNERS);
  localparam logic [CNT_W-1:0] CNT_ALL_NEG = CNT_W'(-CORNERS);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(CORNERS - 1);

  // One corner beat
  typedef struct packed {
    logic signed [CLIP_W-1:0] clip_x;
    logic signed [CLIP_W-1:0] clip_y;
    logic signed [CLIP_W-1:0] clip_z;
    logic signed [CLIP_W-1:0] clip_w;
    logic signed [SCR_W-1:0]  win_right;
    logic signed [SCR_W-1:0]  win_left;
    logic signed [SCR_W-1:0]  win_top;
    logic signed [SCR_W-1:0]  win_bottom;
    logic                     skip;
  } in_t;

  // One result beat
  typedef struct packed {
    logic                    visible;
    logic signed [SCR_W-1:0] new_right;
    logic signed [SCR_W-1:0] new_left;
    logic signed [SCR_W-1:0] new_top;
    logic signed [SCR_W-1:0] new_bottom;
  } out_t;

  // Screen-space corner after the divide
  typedef struct packed {
    logic signed [SCR_W-1:0] x;
    logic signed [SCR_W-1:0] y;
    logic signed [SCR_W-1:0] z;
  } scr_t;

  // Accumulator status seen by the control
  typedef struct packed {
    logic                    last;
    logic [CNT_W-1:0]        horiz;
    logic [CNT_W-1:0]        vert;
    logic [CNT_W-1:0]        depth;
    logic signed [SCR_W-1:0] bound_right;
    logic signed [SCR_W-1:0] bound_left;
    logic signed [SCR_W-1:0] bound_top;
    logic signed [SCR_W-1:0] bound_bottom;
  } acc_st_t;

endpackage

`default_nettype wire

// File: rtl/psbc_div.sv
`default_nettype none

// Radix-2 restoring divider: (|num| << 16) / |den|, signed, saturated to 24 bits.
// Numerator bits shift in one per cycle; one quotient bit leaves per cycle.
module psbc_div (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  input  wire logic signed [psbc_pkg::CLIP_W-1:0]       num,
  input  wire logic signed [psbc_pkg::CLIP_W-1:0]       den,
  output logic                                          done,
  output logic signed [psbc_pkg::SCR_W-1:0]             res
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PREP = 4'b0010,
    D_RUN  = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_t;

  dstate_t                              state_r, state_nxt;
  logic [psbc_pkg::CLIP_W-1:0]          an_r, an_nxt;
  logic [psbc_pkg::CLIP_W-1:0]          aw_r, aw_nxt;
  logic                                 neg_r, neg_nxt;
  logic                                 zero_r, zero_nxt;
  logic                                 ovf_r, ovf_nxt;
  logic [psbc_pkg::CLIP_W-1:0]          rem_r, rem_nxt;
  logic [psbc_pkg::SCR_W-1:0]           sh_r, sh_nxt;
  logic [psbc_pkg::SCR_W-1:0]           q_r, q_nxt;
  logic [psbc_pkg::STEP_W-1:0]          cnt_r, cnt_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]    res_r, res_nxt;
  logic                                 done_r, done_nxt;

  logic [psbc_pkg::CLIP_W:0]            trial;
  logic [psbc_pkg::CLIP_W+1:0]          diff;
  logic                                 ge;

  // One restoring step: bring down the next numerator bit, try subtract
  always_comb begin
    trial = {rem_r, sh_r[psbc_pkg::SCR_W-1]};
    diff  = {1'b0, trial} - {2'b00, aw_r};
    ge    = ~diff[psbc_pkg::CLIP_W+1];
  end

  always_comb begin
    state_nxt = state_r;
    an_nxt    = an_r;
    aw_nxt    = aw_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          an_nxt    = num[psbc_pkg::CLIP_W-1] ? (~num + 1'b1) : num;
          aw_nxt    = den[psbc_pkg::CLIP_W-1] ? (~den + 1'b1) : den;
          neg_nxt   = num[psbc_pkg::CLIP_W-1];
          zero_nxt  = (num == '0);
          state_nxt = D_PREP;
        end
      end
      D_PREP: begin
        // quotient reaches 2^24 exactly when |num| >= |den| << 8 (covers den of zero)
        ovf_nxt   = (aw_r[psbc_pkg::CLIP_W-1:psbc_pkg::SCR_W] == '0) &&
                    (an_r >= {aw_r[psbc_pkg::SCR_W-1:0], 8'd0});
        rem_nxt   = {8'd0, an_r[psbc_pkg::CLIP_W-1:8]};
        sh_nxt    = {an_r[7:0], 16'd0};
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = D_RUN;
      end
      D_RUN: begin
        rem_nxt = ge ? diff[psbc_pkg::CLIP_W-1:0] : trial[psbc_pkg::CLIP_W-1:0];
        sh_nxt  = {sh_r[psbc_pkg::SCR_W-2:0], 1'b0};
        q_nxt   = {q_r[psbc_pkg::SCR_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == psbc_pkg::STEP_W'(psbc_pkg::DIV_STEPS - 1)) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        // sign and saturation
        if (zero_r) begin
          res_nxt = '0;
        end else if (ovf_r) begin
          res_nxt = neg_r ? psbc_pkg::SCR_MIN : psbc_pkg::SCR_MAX;
        end else if (neg_r) begin
          res_nxt = (q_r > 24'h800000) ? psbc_pkg::SCR_MIN : $signed(~q_r + 1'b1);
        end else begin
          res_nxt = q_r[psbc_pkg::SCR_W-1] ? psbc_pkg::SCR_MAX : $signed(q_r);
        end
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    an_r   <= an_nxt;
    aw_r   <= aw_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    ovf_r  <= ovf_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// File: rtl/psbc_acc.sv
`default_nettype none

// Per-portal accumulator: side counts, running screen bounds, corner index.
module psbc_acc (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd,
  input  wire logic              clr,
  input  wire psbc_pkg::scr_t    scr,
  input  wire psbc_pkg::in_t     win,
  output psbc_pkg::acc_st_t      st
);

  logic [psbc_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [psbc_pkg::CNT_W-1:0]  horiz_r, horiz_nxt;
  logic signed [psbc_pkg::CNT_W-1:0]  vert_r, vert_nxt;
  logic signed [psbc_pkg::CNT_W-1:0]  depth_r, depth_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  br_r, br_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  bl_r, bl_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  bt_r, bt_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  bb_r, bb_nxt;

  logic signed [psbc_pkg::SCR_W-1:0]  vx, vy, vz;
  logic signed [psbc_pkg::SCR_W-1:0]  wr, wl, wt, wb;
  logic signed [psbc_pkg::SCR_W-1:0]  base_r, base_l, base_t, base_b;
  logic                               behind;
  logic                               last;

  assign vx     = scr.x;
  assign vy     = scr.y;
  assign vz     = scr.z;
  assign wr     = win.win_right;
  assign wl     = win.win_left;
  assign wt     = win.win_top;
  assign wb     = win.win_bottom;
  assign behind = vz[psbc_pkg::SCR_W-1];
  assign last   = (idx_r == psbc_pkg::IDX_LAST);

  // A corner behind the near plane opens the bounds to full screen first
  always_comb begin
    base_r = behind ? psbc_pkg::Q_ONE     : br_r;
    base_l = behind ? psbc_pkg::Q_NEG_ONE : bl_r;
    base_t = behind ? psbc_pkg::Q_ONE     : bt_r;
    base_b = behind ? psbc_pkg::Q_NEG_ONE : bb_r;
  end

  always_comb begin
    idx_nxt   = idx_r;
    horiz_nxt = horiz_r;
    vert_nxt  = vert_r;
    depth_nxt = depth_r;
    br_nxt    = br_r;
    bl_nxt    = bl_r;
    bt_nxt    = bt_r;
    bb_nxt    = bb_r;
    if (upd) begin
      if (vx > wr) begin
        horiz_nxt = horiz_r + 1'b1;
      end else if (vx < wl) begin
        horiz_nxt = horiz_r - 1'b1;
      end
      if (vy > wt) begin
        vert_nxt = vert_r + 1'b1;
      end else if (vy < wb) begin
        vert_nxt = vert_r - 1'b1;
      end
      if (vz > psbc_pkg::Q_ONE) begin
        depth_nxt = depth_r + 1'b1;
      end else if (behind) begin
        depth_nxt = depth_r - 1'b1;
      end
      br_nxt = (vx > base_r) ? vx : base_r;
      bl_nxt = (vx < base_l) ? vx : base_l;
      bt_nxt = (vy > base_t) ? vy : base_t;
      bb_nxt = (vy < base_b) ? vy : base_b;
      if (!last) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (clr) begin
      idx_nxt   = '0;
      horiz_nxt = '0;
      vert_nxt  = '0;
      depth_nxt = '0;
      br_nxt    = psbc_pkg::Q_NEG_ONE;
      bl_nxt    = psbc_pkg::Q_ONE;
      bt_nxt    = psbc_pkg::Q_NEG_ONE;
      bb_nxt    = psbc_pkg::Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      horiz_r <= '0;
      vert_r  <= '0;
      depth_r <= '0;
      br_r    <= psbc_pkg::Q_NEG_ONE;
      bl_r    <= psbc_pkg::Q_ONE;
      bt_r    <= psbc_pkg::Q_NEG_ONE;
      bb_r    <= psbc_pkg::Q_ONE;
    end else begin
      idx_r   <= idx_nxt;
      horiz_r <= horiz_nxt;
      vert_r  <= vert_nxt;
      depth_r <= depth_nxt;
      br_r    <= br_nxt;
      bl_r    <= bl_nxt;
      bt_r    <= bt_nxt;
      bb_r    <= bb_nxt;
    end
  end

  always_comb begin
    st.last         = last;
    st.horiz        = horiz_r;
    st.vert         = vert_r;
    st.depth        = depth_r;
    st.bound_right  = br_r;
    st.bound_left   = bl_r;
    st.bound_top    = bt_r;
    st.bound_bottom = bb_r;
  end

endmodule

`default_nettype wire

// File: rtl/portal_screen_bounds_cull_top.sv
// Portal screen-bounds cull. Feed the eight clip-space corners of one portal box as
// eight input beats, each carrying the current window edges and skip; after the
// eighth beat one result beat reports visible and the window narrowed to the
// portal's screen bounds (or the last beat's window unchanged when culled). A corner
// keeps in_ready low from its accept until it has been folded in, so a new corner
// is taken only once the last one is done: x, y and z are divided by |w| in turn on
// one shared radix-2 divider, then the corner is folded into the counts and bounds.
// The last corner of a portal then holds in_ready low through the narrowing and the
// result load. The result beat waits in one output register; if it has not been
// taken when the next portal's last corner is ready to load, that corner holds and
// in_ready stays low until the waiting beat goes out. Coordinates are Q16.16, screen
// values Q7.16.
`default_nettype none

module portal_screen_bounds_cull_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire psbc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output psbc_pkg::out_t      out_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_UPD  = 6'b000100,
    S_NAR1 = 6'b001000,
    S_NAR2 = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    C_X = 2'd0,
    C_Y = 2'd1,
    C_Z = 2'd2
  } coord_t;

  state_t                             state_r, state_nxt;
  coord_t                             sel_r, sel_nxt;
  logic                               start_r, start_nxt;
  psbc_pkg::in_t                      in_r, in_nxt;
  psbc_pkg::scr_t                     scr_r, scr_nxt;
  logic                               vis_r, vis_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  nr_r, nr_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  nl_r, nl_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  nt_r, nt_nxt;
  logic signed [psbc_pkg::SCR_W-1:0]  nb_r, nb_nxt;
  logic                               out_valid_r, out_valid_nxt;
  psbc_pkg::out_t                     out_r, out_nxt;

  logic signed [psbc_pkg::CLIP_W-1:0] div_num;
  logic                               div_done;
  logic signed [psbc_pkg::SCR_W-1:0]  div_res;
  logic                               acc_upd;
  logic                               acc_clr;
  psbc_pkg::acc_st_t                  acc_st;
  logic                               all_out;
  logic signed [psbc_pkg::SCR_W-1:0]  wr, wl, wt, wb;

  assign wr = in_r.win_right;
  assign wl = in_r.win_left;
  assign wt = in_r.win_top;
  assign wb = in_r.win_bottom;

  // Numerator for the coordinate in flight
  always_comb begin
    case (sel_r)
      C_X:     div_num = in_r.clip_x;
      C_Y:     div_num = in_r.clip_y;
      C_Z:     div_num = in_r.clip_z;
      default: div_num = in_r.clip_x;
    endcase
  end

  psbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (div_num),
    .den   (in_r.clip_w),
    .done  (div_done),
    .res   (div_res)
  );

  psbc_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (acc_upd),
    .clr   (acc_clr),
    .scr   (scr_r),
    .win   (in_r),
    .st    (acc_st)
  );

  // Every corner past one side of some axis
  assign all_out = (acc_st.horiz == psbc_pkg::CNT_ALL_POS) ||
                   (acc_st.horiz == psbc_pkg::CNT_ALL_NEG) ||
                   (acc_st.vert  == psbc_pkg::CNT_ALL_POS) ||
                   (acc_st.vert  == psbc_pkg::CNT_ALL_NEG) ||
                   (acc_st.depth == psbc_pkg::CNT_ALL_POS) ||
                   (acc_st.depth == psbc_pkg::CNT_ALL_NEG);

  // Control sequence
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    start_nxt     = 1'b0;
    in_nxt        = in_r;
    scr_nxt       = scr_r;
    vis_nxt       = vis_r;
    nr_nxt        = nr_r;
    nl_nxt        = nl_r;
    nt_nxt        = nt_r;
    nb_nxt        = nb_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    acc_upd       = 1'b0;
    acc_clr       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          sel_nxt   = C_X;
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          case (sel_r)
            C_X: begin
              scr_nxt.x = div_res;
              sel_nxt   = C_Y;
              start_nxt = 1'b1;
            end
            C_Y: begin
              scr_nxt.y = div_res;
              sel_nxt   = C_Z;
              start_nxt = 1'b1;
            end
            default: begin
              scr_nxt.z = div_res;
              state_nxt = S_UPD;
            end
          endcase
        end
      end
      S_UPD: begin
        acc_upd   = 1'b1;
        state_nxt = acc_st.last ? S_NAR1 : S_IDLE;
      end
      S_NAR1: begin
        // decide, then narrow right and top against the original pairs
        vis_nxt = !in_r.skip && !all_out;
        nr_nxt  = wr;
        nl_nxt  = wl;
        nt_nxt  = wt;
        nb_nxt  = wb;
        if (vis_nxt) begin
          if (acc_st.bound_right < wr && acc_st.bound_right > wl) begin
            nr_nxt = acc_st.bound_right;
          end
          if (acc_st.bound_top < wt && acc_st.bound_top > wb) begin
            nt_nxt = acc_st.bound_top;
          end
        end
        state_nxt = S_NAR2;
      end
      S_NAR2: begin
        // left and bottom see the already narrowed right and top
        if (vis_r) begin
          if (acc_st.bound_left < nr_r && acc_st.bound_left > nl_r) begin
            nl_nxt = acc_st.bound_left;
          end
          if (acc_st.bound_bottom < nt_r && acc_st.bound_bottom > nb_r) begin
            nb_nxt = acc_st.bound_bottom;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.visible    = vis_r;
          out_nxt.new_right  = nr_r;
          out_nxt.new_left   = nl_r;
          out_nxt.new_top    = nt_r;
          out_nxt.new_bottom = nb_r;
          out_valid_nxt      = 1'b1;
          acc_clr            = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= C_X;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r  <= in_nxt;
    scr_r <= scr_nxt;
    vis_r <= vis_nxt;
    nr_r  <= nr_nxt;
    nl_r  <= nl_nxt;
    nt_r  <= nt_nxt;
    nb_r  <= nb_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Divider results only arrive while a corner is being divided
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result outside divide phase");

  // An accepted corner always kicks off the x divide
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (start_r && sel_r == C_X && state_r == S_DIV))
    else $error("accepted corner did not start divide");

  // A free output register takes the result at once
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded from finish state");

endmodule

`default_nettype wire
